### rtl/mfom_pkg.sv
// Shared constants, types and sine polynomial steps for the mecanum mixer.
// No dependencies; every other file in rtl/ depends on this package.
`default_nettype none
package mfom_pkg;

  localparam int SIN_A = 51437;
  localparam int SIN_B = 20953;
  localparam int SIN_C = 2284;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT = CFG_IDX_W'(1);

  localparam logic [15:0] GAIN_RST = 16'd256;
  localparam logic [14:0] MAXO_RST = 15'd5000;

  localparam int ABS_W    = 23;              // wheel magnitude before limiting
  localparam int NUM_W    = 38;              // magnitude times limit
  localparam int DIV_BITS = 15;              // quotient never exceeds the limit
  localparam int TOP_STG  = 8;
  localparam int NST      = TOP_STG + DIV_BITS + 1;

  typedef struct packed {
    logic [14:0] x;
    logic [14:0] x2;
    logic [15:0] t;
    logic [1:0]  q;
  } sin_t;

  typedef struct packed {
    logic signed [27:0] cx;
    logic signed [27:0] cy;
    logic signed [15:0] z;
  } drv_t;

  typedef struct packed {
    logic        scale;
    logic        neg;
    logic [15:0] wlo;
  } side_t;

  // fold the angle into the first quarter wave and square it
  function automatic sin_t sin_prep(logic [15:0] a);
    sin_t        r;
    logic [29:0] sq;
    r.q  = a[15:14];
    r.x  = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    sq   = 30'(r.x) * 30'(r.x);
    r.x2 = sq[28:14];
    r.t  = '0;
    return r;
  endfunction

  function automatic sin_t sin_step1(sin_t s);
    sin_t        r;
    logic [26:0] p;
    r   = s;
    p   = 27'(s.x2) * 27'(SIN_C);
    r.t = 16'(16'(SIN_B) - 16'(p[26:14]));
    return r;
  endfunction

  function automatic sin_t sin_step2(sin_t s);
    sin_t        r;
    logic [29:0] p;
    r   = s;
    p   = 30'(s.x2) * 30'(s.t);
    r.t = 16'(16'(SIN_A) - p[29:14]);
    return r;
  endfunction

  function automatic logic signed [15:0] sin_final(sin_t s);
    logic [30:0] p;
    logic [14:0] mag;
    p   = 31'(s.x) * 31'(s.t);
    mag = (p[30:14] > 17'd32767) ? 15'h7fff : p[28:14];
    return s.q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

### rtl/mfom_if.sv
// Handshake channel interfaces for the mecanum mixer: command, result, config.
// Depends on mfom_pkg for the config index width.
`default_nettype none
interface mfom_in_if;
  logic               valid;
  logic               ready;
  logic [10:0]        stick_x;
  logic [10:0]        stick_y;
  logic signed [15:0] rotate_drive;
  logic [15:0]        heading;
  modport source (output valid, stick_x, stick_y, rotate_drive, heading, input ready);
  modport sink   (input valid, stick_x, stick_y, rotate_drive, heading, output ready);
endinterface

interface mfom_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_one;
  logic signed [15:0] wheel_two;
  logic signed [15:0] wheel_three;
  logic signed [15:0] wheel_four;
  modport source (output valid, wheel_one, wheel_two, wheel_three, wheel_four, input ready);
  modport sink   (input valid, wheel_one, wheel_two, wheel_three, wheel_four, output ready);
endinterface

interface mfom_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mfom_pkg::CFG_IDX_W-1:0]   index;
  logic [15:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/mfom_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on mfom_pkg; stage loads come from the top-level flow control.
`default_nettype none
module mfom_div (
  input  wire logic                          clk,
  input  wire logic [mfom_pkg::DIV_BITS-1:0] ld,
  input  wire logic [mfom_pkg::ABS_W-1:0]    m_i,
  input  wire logic [mfom_pkg::NUM_W-1:0]    num_i,
  input  wire mfom_pkg::side_t               side_i,
  output logic [mfom_pkg::DIV_BITS-1:0]      q_o,
  output mfom_pkg::side_t                    side_o
);
  import mfom_pkg::*;

  logic [NUM_W-1:0]    rem_r [DIV_BITS];
  logic [ABS_W-1:0]    m_r   [DIV_BITS];
  logic [DIV_BITS-1:0] q_r   [DIV_BITS];
  side_t               sd_r  [DIV_BITS];

  logic [NUM_W-1:0]    rem_in [DIV_BITS];
  logic [ABS_W-1:0]    m_in   [DIV_BITS];
  logic [DIV_BITS-1:0] q_in   [DIV_BITS];
  side_t               sd_in  [DIV_BITS];

  always_comb begin
    rem_in[0] = num_i;
    m_in[0]   = m_i;
    q_in[0]   = '0;
    sd_in[0]  = side_i;
    for (int j = 1; j < DIV_BITS; j++) begin
      rem_in[j] = rem_r[j-1];
      m_in[j]   = m_r[j-1];
      q_in[j]   = q_r[j-1];
      sd_in[j]  = sd_r[j-1];
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_st
    localparam int SH = DIV_BITS - 1 - j;
    logic [NUM_W-1:0] trial;
    logic             ge;
    assign trial = NUM_W'(m_in[j]) << SH;
    assign ge    = rem_in[j] >= trial;
    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_r[j] <= ge ? NUM_W'(rem_in[j] - trial) : rem_in[j];
        q_r[j]   <= q_in[j] | (ge ? (DIV_BITS'(1) << SH) : '0);
        m_r[j]   <= m_in[j];
        sd_r[j]  <= sd_in[j];
      end
    end
  end

  assign q_o    = q_r[DIV_BITS-1];
  assign side_o = sd_r[DIV_BITS-1];

endmodule
`default_nettype wire

### rtl/mecanum_field_oriented_mixer.sv
// Field-oriented mecanum mixer: stick scaling, heading rotation, wheel mix, limit.
// Depends on mfom_pkg, mfom_if and mfom_div.
// Throughput: one command per cycle while the result side is not stalling.
// The 15-stage divider (one quotient bit per stage) sets the depth.
// Reset (rst_n low, synchronous) empties the pipeline and loads stick_gain 256, max_output 5000.
`default_nettype none
module mecanum_field_oriented_mixer (
  input  wire logic clk,
  input  wire logic rst_n,
  mfom_in_if.sink   in_s,
  mfom_out_if.source out_s,
  mfom_cfg_if.sink  cfg_s
);
  import mfom_pkg::*;

  // ---------------- configuration ----------------
  logic [15:0] gain_r;
  logic [14:0] maxo_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      maxo_r <= MAXO_RST;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_STICK_GAIN: gain_r <= cfg_s.data;
        REG_MAX_OUTPUT: maxo_r <= cfg_s.data[14:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------- flow control ----------------
  // A stage takes new data when it is empty or the stage after it moves.
  // Bubbles collapse, so commands keep entering while a result waits.
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_s.ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_r[i] || rdy[i+1];
  end

  assign in_s.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_s.valid;
      for (int i = 1; i < NST; i++) if (rdy[i]) v_r[i] <= v_r[i-1];
    end
  end

  // ---------------- stages 1-4: stick scaling and sine/cosine ----------------
  sin_t sn_r [3];
  sin_t cs_r [3];
  drv_t dv_r [4];

  logic signed [11:0] dx, dy;
  drv_t               dv_nxt;

  always_comb begin
    dx = $signed({1'b0, in_s.stick_x}) - 12'sd1024;
    dy = $signed({1'b0, in_s.stick_y}) - 12'sd1024;
    dv_nxt.cx = 28'(dx) * 28'($signed({1'b0, gain_r}));
    dv_nxt.cy = 28'(dy) * 28'($signed({1'b0, gain_r}));
    dv_nxt.z  = in_s.rotate_drive;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sn_r[0] <= sin_prep(in_s.heading);
      cs_r[0] <= sin_prep(16'(in_s.heading + 16'd16384));  // cosine leads by a quarter turn
      dv_r[0] <= dv_nxt;
    end
    if (rdy[1]) begin
      sn_r[1] <= sin_step1(sn_r[0]);
      cs_r[1] <= sin_step1(cs_r[0]);
      dv_r[1] <= dv_r[0];
    end
    if (rdy[2]) begin
      sn_r[2] <= sin_step2(sn_r[1]);
      cs_r[2] <= sin_step2(cs_r[1]);
      dv_r[2] <= dv_r[1];
    end
  end

  logic signed [15:0] s_r, c_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s_r     <= sin_final(sn_r[2]);
      c_r     <= sin_final(cs_r[2]);
      dv_r[3] <= dv_r[2];
    end
  end

  // ---------------- stage 5: rotation products ----------------
  logic signed [43:0] p_cys_r, p_cxc_r, p_cyc_r, p_cxs_r;
  logic signed [15:0] z5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      p_cys_r <= 44'(dv_r[3].cy) * 44'(s_r);
      p_cxc_r <= 44'(dv_r[3].cx) * 44'(c_r);
      p_cyc_r <= 44'(dv_r[3].cy) * 44'(c_r);
      p_cxs_r <= 44'(dv_r[3].cx) * 44'(s_r);
      z5_r    <= dv_r[3].z;
    end
  end

  // ---------------- stage 6: sums, shift toward zero ----------------
  logic signed [44:0] vx, vy, bx, by;
  logic signed [21:0] x_r, y_r;
  logic signed [15:0] z6_r;

  always_comb begin
    vx = 45'(p_cys_r) + 45'(p_cxc_r);
    vy = 45'(p_cyc_r) - 45'(p_cxs_r);
    // bias negatives so the arithmetic shift truncates toward zero
    bx = vx + (vx[44] ? 45'sd8388607 : 45'sd0);
    by = vy + (vy[44] ? 45'sd8388607 : 45'sd0);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      x_r  <= 22'(bx >>> 23);
      y_r  <= 22'(by >>> 23);
      z6_r <= z5_r;
    end
  end

  // ---------------- stage 7: wheel mix ----------------
  logic signed [23:0] xe, ye, ze;
  logic signed [23:0] w_nxt [4];
  logic signed [23:0] w_r   [4];
  logic [ABS_W-1:0]   a_r   [4];

  always_comb begin
    xe = 24'(x_r);
    ye = 24'(y_r);
    ze = 24'(z6_r);
    w_nxt[0] = -xe - ye - ze;
    w_nxt[1] = -xe + ye - ze;
    w_nxt[2] =  xe + ye - ze;
    w_nxt[3] =  xe - ye - ze;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int k = 0; k < 4; k++) begin
        w_r[k] <= w_nxt[k];
        a_r[k] <= w_nxt[k][23] ? ABS_W'(-w_nxt[k]) : ABS_W'(w_nxt[k]);
      end
    end
  end

  // ---------------- stage 8: peak magnitude and numerators ----------------
  logic [ABS_W-1:0] m01, m23, m_nxt;
  logic [ABS_W-1:0] m8_r;
  logic [NUM_W-1:0] num_r [4];
  side_t            sd8_r [4];

  always_comb begin
    m01   = (a_r[0] > a_r[1]) ? a_r[0] : a_r[1];
    m23   = (a_r[2] > a_r[3]) ? a_r[2] : a_r[3];
    m_nxt = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      m8_r <= m_nxt;
      for (int k = 0; k < 4; k++) begin
        num_r[k]       <= NUM_W'(a_r[k]) * NUM_W'(maxo_r);
        sd8_r[k].scale <= (m_nxt != '0) && (m_nxt >= ABS_W'(maxo_r));
        sd8_r[k].neg   <= w_r[k][23];
        sd8_r[k].wlo   <= w_r[k][15:0];
      end
    end
  end

  // ---------------- stages 9-23: limit scaling ----------------
  logic [DIV_BITS-1:0] q_d  [4];
  side_t               sd_d [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    mfom_div u_div (
      .clk    (clk),
      .ld     (rdy[TOP_STG +: DIV_BITS]),
      .m_i    (m8_r),
      .num_i  (num_r[k]),
      .side_i (sd8_r[k]),
      .q_o    (q_d[k]),
      .side_o (sd_d[k])
    );
  end

  // ---------------- stage 24: sign and output register ----------------
  logic signed [15:0] val  [4];
  logic signed [15:0] wh_r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (sd_d[k].scale) val[k] = sd_d[k].neg ? -$signed({1'b0, q_d[k]}) : $signed({1'b0, q_d[k]});
      else               val[k] = $signed(sd_d[k].wlo);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      wh_r[0] <= val[0];
      wh_r[1] <= -val[1];  // wheels two and four run mirrored
      wh_r[2] <= val[2];
      wh_r[3] <= -val[3];
    end
  end

  assign out_s.valid       = v_r[NST-1];
  assign out_s.wheel_one   = wh_r[0];
  assign out_s.wheel_two   = wh_r[1];
  assign out_s.wheel_three = wh_r[2];
  assign out_s.wheel_four  = wh_r[3];

  // ---------------- assertions ----------------
  logic [16:0] abs_one;
  assign abs_one = out_s.wheel_one[15] ? 17'(-$signed({out_s.wheel_one[15], out_s.wheel_one}))
                                       : {1'b0, out_s.wheel_one};

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> (abs_one <= {2'b0, maxo_r}))
    else $error("wheel one exceeds the drive limit");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_s.ready) |-> !in_s.ready)
    else $error("command taken while the pipeline is full and stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> v_r[0])
    else $error("transferred command lost at pipeline entry");

endmodule
`default_nettype wire

### tb/sv/mfom_scoreboard.sv
// Wheel-drive predictor and expected-result store for the mecanum mixer testbench.
// Depends on mfom_pkg for the register indices, reset values and sine constants.
class mfom_wheel_scoreboard;
  typedef struct {
    logic signed [15:0] w1, w2, w3, w4;
  } wheels_t;

  logic [15:0] gain;
  logic [14:0] limit;
  wheels_t     pending[$];
  int          errors;
  int          checked;

  function new();
    gain    = mfom_pkg::GAIN_RST;
    limit   = mfom_pkg::MAXO_RST;
    errors  = 0;
    checked = 0;
  endfunction

  function void write_reg(logic [mfom_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    if (idx == mfom_pkg::REG_STICK_GAIN) gain = data;
    else if (idx == mfom_pkg::REG_MAX_OUTPUT) limit = data[14:0];
  endfunction

  // quarter-wave odd polynomial sine, Q1.15
  function longint sine(logic [15:0] h);
    longint unsigned q, r, x, x2, t1, t2, s;
    q  = h >> 14;
    r  = h & 16'h3fff;
    x  = q[0] ? (16384 - r) : r;
    x2 = (x * x) >> 14;
    t1 = (mfom_pkg::SIN_B - ((x2 * mfom_pkg::SIN_C) >> 14)) & 32'hffffffff;
    t2 = (mfom_pkg::SIN_A - ((x2 * t1) >> 14)) & 32'hffffffff;
    s  = ((x * t2) & 32'hffffffff) >> 14;
    if (s > 32767) s = 32767;
    return q[1] ? -longint'(s) : longint'(s);
  endfunction

  function longint trunc_shift(longint v);
    return (v < 0) ? -((-v) >>> 23) : (v >>> 23);
  endfunction

  function longint scale(longint v, longint m);
    longint a;
    a = (v < 0) ? -v : v;
    a = (a * limit) / m;
    return (v < 0) ? -a : a;
  endfunction

  function void note_command(logic [10:0] sx, logic [10:0] sy, logic signed [15:0] rz,
                             logic [15:0] hd);
    longint cx, cy, s, c, x, y, z, m, a;
    longint w[4];
    wheels_t e;
    cx = (longint'(sx) - 1024) * longint'(gain);
    cy = (longint'(sy) - 1024) * longint'(gain);
    z  = rz;
    s  = sine(hd);
    c  = sine(hd + 16'd16384);
    x  = trunc_shift(cy * s + cx * c);
    y  = trunc_shift(cy * c - cx * s);
    w[0] = -x - y - z;
    w[1] = -x + y - z;
    w[2] = x + y - z;
    w[3] = x - y - z;
    m = 0;
    foreach (w[k]) begin
      a = (w[k] < 0) ? -w[k] : w[k];
      if (a > m) m = a;
    end
    if (m > 0 && m >= limit) foreach (w[k]) w[k] = scale(w[k], m);
    e.w1 = 16'(w[0]);
    e.w2 = 16'(-w[1]);
    e.w3 = 16'(w[2]);
    e.w4 = 16'(-w[3]);
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] a1, a2, a3, a4);
    wheels_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %0d %0d %0d %0d", $time, a1, a2, a3, a4);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a1 !== e.w1) begin
      $display("%0t: wheel_one expected %0d actual %0d", $time, e.w1, a1); errors++;
    end
    if (a2 !== e.w2) begin
      $display("%0t: wheel_two expected %0d actual %0d", $time, e.w2, a2); errors++;
    end
    if (a3 !== e.w3) begin
      $display("%0t: wheel_three expected %0d actual %0d", $time, e.w3, a3); errors++;
    end
    if (a4 !== e.w4) begin
      $display("%0t: wheel_four expected %0d actual %0d", $time, e.w4, a4); errors++;
    end
  endfunction
endclass

### tb/sv/tb_mecanum_field_oriented_mixer.sv
// Top-level testbench for mecanum_field_oriented_mixer: drives commands and register
// writes, checks each wheel result. Depends on mfom_pkg, mfom_if, mfom_scoreboard.
module tb_mecanum_field_oriented_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import mfom_pkg::*;

  localparam int LATENCY = 24;

  logic clk;
  logic rst_n;
  bit   calm;        // when set, neither side idles
  int   cmd_count;

  mfom_in_if  in_s();
  mfom_out_if out_s();
  mfom_cfg_if cfg_s();

  mecanum_field_oriented_mixer u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_s), .out_s(out_s), .cfg_s(cfg_s)
  );

  mfom_wheel_scoreboard wheel_sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_s.valid = 1'b0;
    in_s.stick_x = '0;
    in_s.stick_y = '0;
    in_s.rotate_drive = '0;
    in_s.heading = '0;
    out_s.ready = 1'b0;
    cfg_s.valid = 1'b0;
    cfg_s.index = '0;
    cfg_s.data = '0;
  end

  // Receiver: stall at random except during calm stretches; check each transfer.
  always @(posedge clk) begin
    if (rst_n && out_s.valid && out_s.ready)
      wheel_sb.check_result(out_s.wheel_one, out_s.wheel_two,
                            out_s.wheel_three, out_s.wheel_four);
    out_s.ready <= rst_n && (calm || $urandom_range(99) >= 28);
  end

  // Write one register; only called while the pipeline is empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_s.valid <= 1'b1;
    cfg_s.index <= idx;
    cfg_s.data  <= data;
    do @(posedge clk); while (!cfg_s.ready);
    wheel_sb.write_reg(idx, data);
    cfg_s.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Present one command and hold it until the transfer.
  task automatic send_cmd(logic [10:0] sx, logic [10:0] sy, logic [15:0] rz,
                          logic [15:0] hd);
    while (!calm && $urandom_range(99) < 28) begin
      in_s.valid <= 1'b0;
      @(posedge clk);
    end
    in_s.valid        <= 1'b1;
    in_s.stick_x      <= sx;
    in_s.stick_y      <= sy;
    in_s.rotate_drive <= rz;
    in_s.heading      <= hd;
    do @(posedge clk); while (!in_s.ready);
    wheel_sb.note_command(sx, sy, rz, hd);
    cmd_count++;
  endtask

  task automatic drop_valid();
    in_s.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the pipeline drain.
  task automatic drain();
    drop_valid();
    while (wheel_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_cmds(int n);
    logic [10:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      // mostly full-range sticks, some near center to stay under the limit
      if ($urandom_range(3) == 0) begin
        sx = 11'(1024 + $signed($urandom_range(64)) - 32);
        sy = 11'(1024 + $signed($urandom_range(64)) - 32);
      end else begin
        sx = 11'($urandom_range(2047));
        sy = 11'($urandom_range(2047));
      end
      send_cmd(sx, sy, $urandom_range(3) == 0 ? 16'($signed($urandom_range(400)) - 200)
                                               : 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] gains[5];
    logic [14:0] limits[5];
    gains  = '{16'd256, 16'd0, 16'hffff, 16'd37, 16'd1024};
    limits = '{15'd5000, 15'd1, 15'h7fff, 15'd200, 15'd12000};
    calm = 1'b0;
    cmd_count = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stick and rotation extremes, cardinal headings, all-zero wheels.
    send_cmd(11'd1024, 11'd1024, 16'd0, 16'd0);
    send_cmd(11'd0, 11'd0, 16'sh8000, 16'd0);
    send_cmd(11'd2047, 11'd2047, 16'sh7fff, 16'hffff);
    send_cmd(11'd2047, 11'd0, 16'd0, 16'd16384);
    send_cmd(11'd0, 11'd2047, 16'd0, 16'd32768);
    send_cmd(11'd1024, 11'd2047, 16'd0, 16'd49152);
    send_cmd(11'd2047, 11'd1024, 16'd100, 16'd8192);
    send_cmd(11'd1025, 11'd1023, -16'sd1, 16'd16383);
    send_cmd(11'd1024, 11'd1024, 16'd4999, 16'd0);
    send_cmd(11'd1024, 11'd1024, 16'd5000, 16'd0);
    send_cmd(11'h555, 11'h2aa, 16'h5555, 16'haaaa);
    send_cmd(11'h2aa, 11'h555, 16'haaaa, 16'h5555);

    // Pause the sender until every expected result is in.
    drain();

    // Walk the register settings, extremes included, with random traffic each.
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_STICK_GAIN, gains[p]);
      write_reg(REG_MAX_OUTPUT, 16'(limits[p]));
      calm = (p == 2);
      random_cmds(p == 2 ? 140 : 90);
      calm = 1'b0;
      if (p == 1) begin
        // Out-of-range index must be ignored.
        drain();
        write_reg(4'd9, 16'h1234);
        random_cmds(10);
      end
      drain();
    end

    $display("ran %0d commands over 5 gain/limit settings, %0d results checked",
             cmd_count, wheel_sb.checked);
    if (wheel_sb.errors == 0 && wheel_sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### mecanum_field_oriented_mixer.f
rtl/mfom_pkg.sv
rtl/mfom_if.sv
rtl/mfom_div.sv
rtl/mecanum_field_oriented_mixer.sv
tb/sv/mfom_scoreboard.sv
tb/sv/tb_mecanum_field_oriented_mixer.sv
